// File: rtl/fpfa_pkg.sv
// Shared types and constants for the fixed-partition fit allocator.
// No dependencies; imported by the controller, the datapath and the top level.
package fpfa_pkg;

    // Default build-time sizes
    localparam int SLOTS_DEFAULT     = 16;
    localparam int SIZE_BITS_DEFAULT = 16;

    // Request field widths
    localparam int OPCODE_W = 2;
    localparam int SLOT_IDX_W = 4;
    localparam int SIZE_VAL_W = 16;
    localparam int IN_TDATA_W = 24;

    // Result field widths
    localparam int LEFTOVER_W = 16;
    localparam int FRAG_W = 24;
    localparam int OUT_TDATA_W = 48;

    localparam logic [FRAG_W-1:0] FRAG_MAX = 24'hFFFFFF;

    // Configuration port
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 5;
    localparam int FIT_MODE_W = 2;
    localparam int PIU_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PARTITIONS = 1'b1;
    localparam logic [FIT_MODE_W-1:0] FIT_MODE_RESET = 2'd0;
    localparam logic [PIU_W-1:0] PIU_RESET = 5'd16;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_WRITE   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_ALLOC   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_RELEASE = 2'd2;

    // Fit modes
    localparam logic [FIT_MODE_W-1:0] MODE_FIRST = 2'd0;
    localparam logic [FIT_MODE_W-1:0] MODE_BEST  = 2'd1;
    localparam logic [FIT_MODE_W-1:0] MODE_WORST = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic latch;       // capture the incoming request
        logic scan_start;  // clear the search pointer and the candidate
        logic scan_step;   // read one slot and advance the pointer
        logic commit;      // apply the request and load the result register
    } fpfa_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic in_alloc;    // incoming request is an allocation
        logic scan_done;   // every searched slot has been issued
        logic out_busy;    // result register holds a result not yet taken
    } fpfa_sts_t;

endpackage

// File: rtl/fpfa_ctrl.sv
// Controller state machine of the fixed-partition fit allocator.
// Depends on fpfa_pkg for the command and status structs.
module fpfa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  fpfa_pkg::fpfa_sts_t sts,
    output fpfa_pkg::fpfa_cmd_t cmd
);
    import fpfa_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.latch = 1'b1;
                    if (sts.in_alloc)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_COMMIT;
                    end
                end
            end
            S_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = S_COMMIT;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_COMMIT:
            begin
                // hold until the result register is free
                if (!sts.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/fpfa_datapath.sv
// Datapath of the fixed-partition fit allocator: size memory, used marks,
// scan pipeline, fit selection, fragmentation total and result register.
// Depends on fpfa_pkg.
module fpfa_datapath #(
    parameter int SLOTS     = fpfa_pkg::SLOTS_DEFAULT,
    parameter int SIZE_BITS = fpfa_pkg::SIZE_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [fpfa_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [fpfa_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic                               cfg_we,
    input  logic [fpfa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fpfa_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  fpfa_pkg::fpfa_cmd_t                cmd,
    output fpfa_pkg::fpfa_sts_t                sts
);
    import fpfa_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int CMP_W = (CNT_W > PIU_W) ? CNT_W : PIU_W;
    localparam int SUM_W = ((SIZE_BITS > FRAG_W) ? SIZE_BITS : FRAG_W) + 1;

    // Configuration
    logic [FIT_MODE_W-1:0] fit_mode_reg;
    logic [PIU_W-1:0]      piu_reg;

    // Captured request
    logic [OPCODE_W-1:0]   op_reg;
    logic [SLOT_IDX_W-1:0] idx_reg;
    logic [SIZE_BITS-1:0]  sz_reg;

    // Storage
    logic [SIZE_BITS-1:0]  size_mem [SLOTS];
    logic [SLOTS-1:0]      used_reg;
    logic [FRAG_W-1:0]     frag_reg;

    // Scan pipeline
    logic [CNT_W-1:0]      ptr_reg;
    logic                  s1_valid_reg;
    logic                  s1_used_reg;
    logic [IDX_W-1:0]      s1_idx_reg;
    logic [SIZE_BITS-1:0]  rd_data_reg;

    // Best candidate so far
    logic                  found_reg;
    logic [IDX_W-1:0]      best_idx_reg;
    logic [SIZE_BITS-1:0]  best_left_reg;

    // Result register
    logic                  out_valid_reg;
    logic                  granted_reg;
    logic [SLOT_IDX_W-1:0] gslot_reg;
    logic [LEFTOVER_W-1:0] left_reg;
    logic [FRAG_W-1:0]     total_reg;

    logic [CMP_W-1:0]      piu_w;
    logic [CMP_W-1:0]      slots_w;
    logic [CNT_W-1:0]      count_eff;
    logic                  cand_ok;
    logic [SIZE_BITS-1:0]  cand_left;
    logic                  take;
    logic [SUM_W-1:0]      frag_sum;
    logic [FRAG_W-1:0]     frag_next;
    logic                  grant;
    logic                  wr_in_range;

    // Search count, saturated to the number of slots
    always_comb
    begin
        piu_w     = CMP_W'(piu_reg);
        slots_w   = CMP_W'(SLOTS);
        count_eff = (piu_w > slots_w) ? CNT_W'(slots_w) : CNT_W'(piu_w);
    end

    always_comb
    begin
        sts.in_alloc  = (s_tdata[OPCODE_W-1:0] == OP_ALLOC);
        sts.scan_done = (ptr_reg == count_eff);
        sts.out_busy  = out_valid_reg && !m_tready;
    end

    // Fit selection on the slot read in the previous cycle
    always_comb
    begin
        cand_ok   = s1_valid_reg && !s1_used_reg && (rd_data_reg >= sz_reg);
        cand_left = rd_data_reg - sz_reg;
        take      = cand_ok && (!found_reg
                    || ((fit_mode_reg == MODE_BEST) && (cand_left < best_left_reg))
                    || ((fit_mode_reg == MODE_WORST) && (cand_left > best_left_reg)));
    end

    always_comb
    begin
        grant    = (op_reg == OP_ALLOC) && found_reg;
        frag_sum = SUM_W'(frag_reg) + SUM_W'(best_left_reg);
        if (op_reg == OP_RELEASE)
        begin
            frag_next = '0;
        end
        else if (grant)
        begin
            frag_next = (frag_sum > SUM_W'(FRAG_MAX)) ? FRAG_MAX : FRAG_W'(frag_sum);
        end
        else
        begin
            frag_next = frag_reg;
        end
        wr_in_range = (32'(idx_reg) < 32'(SLOTS));
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_mode_reg <= FIT_MODE_RESET;
            piu_reg      <= PIU_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FIT_MODE:   fit_mode_reg <= cfg_data[FIT_MODE_W-1:0];
                CFG_PARTITIONS: piu_reg      <= cfg_data[PIU_W-1:0];
            endcase
        end
    end

    // Request capture, size memory, scan data, best candidate and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg  <= s_tdata[OPCODE_W-1:0];
            idx_reg <= s_tdata[OPCODE_W +: SLOT_IDX_W];
            sz_reg  <= SIZE_BITS'(s_tdata[OPCODE_W + SLOT_IDX_W +: SIZE_VAL_W]);
        end
        if (cmd.commit && (op_reg == OP_WRITE) && wr_in_range)
        begin
            size_mem[IDX_W'(idx_reg)] <= sz_reg;
        end
        if (cmd.scan_step)
        begin
            rd_data_reg <= size_mem[ptr_reg[IDX_W-1:0]];
            s1_used_reg <= used_reg[ptr_reg[IDX_W-1:0]];
            s1_idx_reg  <= ptr_reg[IDX_W-1:0];
        end
        if (take)
        begin
            best_idx_reg  <= s1_idx_reg;
            best_left_reg <= cand_left;
        end
        if (cmd.commit)
        begin
            granted_reg <= grant;
            gslot_reg   <= grant ? SLOT_IDX_W'(best_idx_reg) : '0;
            left_reg    <= grant ? LEFTOVER_W'(best_left_reg) : '0;
            total_reg   <= frag_next;
        end
    end

    // Control state: pointer, candidate flag, used marks, total, result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
            used_reg      <= '0;
            frag_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.scan_step;
            if (cmd.scan_start)
            begin
                ptr_reg   <= '0;
                found_reg <= 1'b0;
            end
            else
            begin
                if (cmd.scan_step)
                begin
                    ptr_reg <= ptr_reg + CNT_W'(1);
                end
                if (take)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.commit)
            begin
                frag_reg <= frag_next;
                if (op_reg == OP_RELEASE)
                begin
                    used_reg <= '0;
                end
                else if (grant)
                begin
                    used_reg[best_idx_reg] <= 1'b1;
                end
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, total_reg, left_reg, gslot_reg, granted_reg};

endmodule

// File: rtl/fixed_partition_fit_allocator.sv
// Top level of the fixed-partition fit allocator.
// Depends on fpfa_pkg, fpfa_ctrl and fpfa_datapath.
//
// Usage:
//   Requests enter on the s_* stream channel: write a partition size, ask for
//   an allocation, or release every partition and clear the running total.
//   Each request yields exactly one result on the m_* channel: grant flag,
//   granted slot, leftover and the fragmentation total after the request.
//   The user sets mode and search count on the cfg_* write port only while
//   idle; the block itself does not enforce it.
// Sequencing:
//   A size write, a release or an unknown opcode goes from accept to commit.
//   An allocation reads the search count (partitions_in_use, capped at SLOTS)
//   of slots, one per cycle, from the size memory through its single read
//   port, judges the last slot, then commits once the result register is free.
//   A new request is taken the cycle after the commit.
// Reset:
//   Clears all used marks, the total, the mode (first fit) and the search
//   count (16). Partition sizes stay undefined until written.
// Stall:
//   A result waits in the output register while m_tready is low; the next
//   request is still taken and searched, and its commit holds until the
//   waiting result is taken.
module fixed_partition_fit_allocator #(
    parameter int SLOTS     = fpfa_pkg::SLOTS_DEFAULT,
    parameter int SIZE_BITS = fpfa_pkg::SIZE_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // opcode[1:0], slot_index[5:2], size_value[21:6], zero fill [23:22]
    input  logic [fpfa_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // granted[0], granted_slot[4:1], leftover[20:5],
    // total_fragmentation[44:21], zero fill [47:45]
    output logic [fpfa_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                              cfg_we,
    input  logic [fpfa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fpfa_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import fpfa_pkg::*;

    fpfa_cmd_t cmd;
    fpfa_sts_t sts;

    // Sequence each request: accept, scan (allocations only), commit
    fpfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Hold the partition table, pick the fit and drive the result register
    fpfa_datapath #(
        .SLOTS     (SLOTS),
        .SIZE_BITS (SIZE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
